/* hdl/ymodem_packet_framer_assert.svh */
// Assertion macros for the YMODEM packet framer.
// Depends on nothing; included by the framer module, which checks its own logic.
`ifndef YMODEM_PACKET_FRAMER_ASSERT_SVH
`define YMODEM_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset
`define YPF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset
`define YPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ypf_pkg.sv */
// Package for the YMODEM packet framer: framing codes, result buffer sizes
// and the CRC-16/XMODEM byte update. No dependencies.
package ypf_pkg;

    // Framing codes
    localparam logic [7:0] START_SMALL = 8'h01;
    localparam logic [7:0] START_LARGE = 8'h02;
    localparam logic [7:0] FILL_SMALL  = 8'h00;
    localparam logic [7:0] FILL_LARGE  = 8'h1A;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Result buffer: at most four bytes per item
    localparam int RES_DEPTH = 4;
    localparam int RES_IDX_W = 2;

    typedef logic [RES_IDX_W-1:0] res_idx_t;
    typedef logic [7:0]           byte_t;

    // CRC-16/XMODEM over one byte, MSB first, eight shift steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input byte_t       data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* hdl/ymodem_packet_framer.sv */
// YMODEM packet framer: one payload item in, one to four framed bytes out,
// with a running CRC-16/XMODEM over the payload. Its result bytes leave one
// per cycle while m_ready is high, through a four-byte result buffer: four
// for an item that opens a packet (start code, number, complement, payload
// byte), three for the item that ends it (payload byte, CRC high, CRC low)
// and one for every other item. The next item is taken in the cycle the last
// byte of the current one is taken, so the sustained rate is one item per
// cycle inside a packet while m_ready is high, limited only by the single
// byte-wide result port. There is no clearing pass after reset.
// Depends on ypf_pkg and ymodem_packet_framer_assert.svh.
`include "ymodem_packet_framer_assert.svh"

module ymodem_packet_framer
    import ypf_pkg::*;
#(
    parameter int unsigned LARGE_PAYLOAD = 1024,
    parameter int unsigned SMALL_PAYLOAD = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    // item input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_data_byte,
    input  logic       s_small_packet,
    // framed byte output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_run_last,
    output logic       m_packet_done
);

    localparam int unsigned MAX_PAYLOAD =
        (LARGE_PAYLOAD > SMALL_PAYLOAD) ? LARGE_PAYLOAD : SMALL_PAYLOAD;
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] SIZE_LARGE = CNT_W'(LARGE_PAYLOAD);
    localparam logic [CNT_W-1:0] SIZE_SMALL = CNT_W'(SMALL_PAYLOAD);
    localparam res_idx_t LAST_OPEN  = res_idx_t'(3);
    localparam res_idx_t LAST_CLOSE = res_idx_t'(2);
    localparam res_idx_t LAST_MID   = res_idx_t'(0);

    // Packet state
    logic [CNT_W-1:0] payload_count_reg, payload_count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       seq_reg, seq_next;
    logic             kind_small_reg, kind_small_next;

    // Result buffer
    byte_t    res_byte_reg [RES_DEPTH];
    byte_t    res_byte_next [RES_DEPTH];
    res_idx_t res_idx_reg, res_last_reg, res_last_next;
    logic     res_valid_reg;
    logic     res_done_reg, res_done_next;

    logic             take, out_take, drain_last;
    logic             opening, closing, kind_small;
    logic [7:0]       seq_out, pay_byte;
    logic [15:0]      crc_base, crc_new;
    logic [CNT_W-1:0] count_inc, size;

    // Handshakes: a new item enters as the last byte of the previous one leaves
    assign out_take   = res_valid_reg && m_ready;
    assign drain_last = out_take && (res_idx_reg == res_last_reg);
    assign s_ready    = !res_valid_reg || drain_last;
    assign take       = s_valid && s_ready;

    // Payload byte, CRC and packet bookkeeping for the offered item
    always_comb begin
        opening    = (payload_count_reg == '0);
        kind_small = opening ? s_small_packet : kind_small_reg;
        seq_out    = s_small_packet ? 8'h00 : seq_reg;
        if (s_func) begin
            pay_byte = kind_small ? FILL_SMALL : FILL_LARGE;
        end else begin
            pay_byte = s_data_byte;
        end
        crc_base  = opening ? 16'h0000 : crc_reg;
        crc_new   = crc_byte(crc_base, pay_byte);
        count_inc = (opening ? '0 : payload_count_reg) + CNT_W'(1);
        size      = kind_small ? SIZE_SMALL : SIZE_LARGE;
        closing   = (count_inc >= size);
    end

    // Next state and result bytes
    always_comb begin
        payload_count_next = closing ? '0 : count_inc;
        crc_next           = crc_new;
        kind_small_next    = kind_small;
        seq_next           = seq_reg;
        if (closing) begin
            seq_next = kind_small ? 8'h01 : seq_reg + 8'h01;
        end

        for (int i = 0; i < RES_DEPTH; i++) begin
            res_byte_next[i] = pay_byte;
        end
        res_done_next = 1'b0;
        if (opening) begin
            res_byte_next[0] = kind_small ? START_SMALL : START_LARGE;
            res_byte_next[1] = seq_out;
            res_byte_next[2] = ~seq_out;
            res_byte_next[3] = pay_byte;
            res_last_next    = LAST_OPEN;
        end else if (closing) begin
            res_byte_next[0] = pay_byte;
            res_byte_next[1] = crc_new[15:8];
            res_byte_next[2] = crc_new[7:0];
            res_last_next    = LAST_CLOSE;
            res_done_next    = 1'b1;
        end else begin
            res_last_next    = LAST_MID;
        end
    end

    // Packet state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_count_reg <= '0;
            crc_reg           <= 16'h0000;
            seq_reg           <= 8'h01;
            kind_small_reg    <= 1'b0;
        end else if (take) begin
            payload_count_reg <= payload_count_next;
            crc_reg           <= crc_next;
            seq_reg           <= seq_next;
            kind_small_reg    <= kind_small_next;
        end
    end

    // Result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
        end else if (take) begin
            res_valid_reg <= 1'b1;
            res_idx_reg   <= '0;
        end else if (drain_last) begin
            res_valid_reg <= 1'b0;
        end else if (out_take) begin
            res_idx_reg   <= res_idx_reg + res_idx_t'(1);
        end
    end

    // Result buffer payload
    always_ff @(posedge aclk) begin
        if (take) begin
            res_byte_reg <= res_byte_next;
            res_last_reg <= res_last_next;
            res_done_reg <= res_done_next;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_tx_byte     = res_byte_reg[res_idx_reg];
    assign m_run_last    = (res_idx_reg == res_last_reg);
    assign m_packet_done = res_done_reg && m_run_last;

    // Checks
    `YPF_ASSERT_NOW(a_ready_only_on_last, aclk, aresetn,
        res_valid_reg && s_ready, m_ready && m_run_last,
        "item taken while earlier result bytes still wait")
    `YPF_ASSERT_NOW(a_done_closes_packet, aclk, aresetn,
        m_valid && m_packet_done, payload_count_reg == '0,
        "packet end shown while packet still open")
    `YPF_ASSERT_NOW(a_count_in_range, aclk, aresetn,
        1'b1, payload_count_reg < (kind_small_reg ? SIZE_SMALL : SIZE_LARGE),
        "payload count reached packet size")
    `YPF_ASSERT_NEXT(a_open_four_bytes, aclk, aresetn,
        take && (payload_count_reg == '0), res_last_reg == LAST_OPEN,
        "opening item did not load four result bytes")

endmodule

/* test/ymodem_packet_framer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ymodem_packet_framer: drives payload items,
// predicts the framed byte stream with its own CRC-16/XMODEM and compares.
// Depends on ypf_pkg and the framer RTL.

module ymodem_packet_framer_tb;
    import ypf_pkg::*;

    localparam int unsigned LARGE_PAYLOAD = 1024;
    localparam int unsigned SMALL_PAYLOAD = 128;

    typedef struct {
        logic       func;
        logic [7:0] data;
        logic       small_pkt;
        bit         hurry;   // no sender gap after this item
    } payload_item_t;

    typedef struct {
        logic [7:0] tx;
        logic       last;
        logic       done;
    } framed_byte_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic       s_func         = 1'b0;
    logic [7:0] s_data_byte    = 8'h00;
    logic       s_small_packet = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_run_last;
    logic       m_packet_done;

    payload_item_t items_pending[$];
    framed_byte_t  bytes_due[$];
    int unsigned   mismatches = 0;

    // predictor state
    logic [10:0] fill_count = '0;
    logic [15:0] crc_acc    = '0;
    logic [7:0]  next_seq   = 8'd1;
    logic        open_small = 1'b0;

    // stimulus planner: mirrors packet boundaries while the queue is filled
    int unsigned plan_count = 0;
    logic        plan_small = 1'b0;

    // sender bursts and receiver stall pattern
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    logic [15:0] stall_mask  = '0;
    logic [3:0]  stall_phase = '0;

    ymodem_packet_framer #(
        .LARGE_PAYLOAD(LARGE_PAYLOAD),
        .SMALL_PAYLOAD(SMALL_PAYLOAD)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_data_byte   (s_data_byte),
        .s_small_packet(s_small_packet),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_run_last    (m_run_last),
        .m_packet_done (m_packet_done)
    );

    always #10 aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // CRC-16/XMODEM, one bit at a time from the byte's MSB
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Work out the framed bytes one accepted item causes
    task automatic frame_item(input logic func, input logic [7:0] data,
                              input logic small_pkt);
        logic [7:0]   out_tx[4];
        logic         out_done[4];
        logic [7:0]   seq;
        logic [7:0]   pay;
        int           n;
        framed_byte_t fb;
        n = 0;
        if (fill_count == 0) begin
            open_small  = small_pkt;
            crc_acc     = '0;
            seq         = small_pkt ? 8'h00 : next_seq;
            out_tx[0]   = small_pkt ? START_SMALL : START_LARGE;
            out_tx[1]   = seq;
            out_tx[2]   = ~seq;
            out_done[0] = 1'b0;
            out_done[1] = 1'b0;
            out_done[2] = 1'b0;
            n = 3;
        end
        pay = func ? (open_small ? FILL_SMALL : FILL_LARGE) : data;
        crc_acc     = crc16_step(crc_acc, pay);
        out_tx[n]   = pay;
        out_done[n] = 1'b0;
        n++;
        fill_count = fill_count + 11'd1;
        if (fill_count >= (open_small ? SMALL_PAYLOAD : LARGE_PAYLOAD)) begin
            out_tx[n]     = crc_acc[15:8];
            out_done[n]   = 1'b0;
            out_tx[n+1]   = crc_acc[7:0];
            out_done[n+1] = 1'b1;
            n += 2;
            next_seq   = open_small ? 8'd1 : next_seq + 8'd1;
            fill_count = '0;
        end
        for (int i = 0; i < n; i++) begin
            fb.tx   = out_tx[i];
            fb.last = (i == n - 1);
            fb.done = out_done[i];
            bytes_due.push_back(fb);
        end
    endtask

    task automatic plan_item(input logic func, input logic [7:0] data, input logic small_pkt,
                             input bit hurry);
        payload_item_t it;
        it.func      = func;
        it.data      = data;
        it.small_pkt = small_pkt;
        it.hurry     = hurry;
        items_pending.push_back(it);
        if (plan_count == 0) begin
            plan_small = small_pkt;
        end
        plan_count++;
        if (plan_count >= (plan_small ? SMALL_PAYLOAD : LARGE_PAYLOAD)) begin
            plan_count = 0;
        end
    endtask

    // Fill the open packet to its end: payload then a filler tail, or noise
    task automatic plan_rest(input bit noisy, input bit hurry);
        int unsigned size;
        int unsigned cut;
        size = plan_small ? SMALL_PAYLOAD : LARGE_PAYLOAD;
        cut  = $urandom_range(plan_count, size);
        while (plan_count != 0) begin
            if (noisy) begin
                plan_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), hurry);
            end else begin
                plan_item(plan_count >= cut, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), hurry);
            end
        end
    endtask

    task automatic plan_packet(input logic small_pkt, input bit noisy, input bit hurry);
        plan_item(1'b0, 8'($urandom_range(0, 255)), small_pkt, hurry);
        plan_rest(noisy, hurry);
    endtask

    // Sender: bursts of items with random gaps between them
    always @(posedge aclk) begin : drive_items
        logic          send_now;
        payload_item_t nxt;
        send_now = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                frame_item(s_func, s_data_byte, s_small_packet);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (items_pending.size() != 0) begin
                    nxt = items_pending.pop_front();
                    s_func         <= nxt.func;
                    s_data_byte    <= nxt.data;
                    s_small_packet <= nxt.small_pkt;
                    send_now = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 64);
                        gap_left   = nxt.hurry ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
                s_valid <= send_now;
            end
        end
    end

    // Receiver: checks each byte, stalls on a rotating 16-bit mask
    always @(posedge aclk) begin : collect_bytes
        framed_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %h", m_tx_byte));
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tx_byte !== want.tx) begin
                        flag_mismatch($sformatf("tx_byte got %h want %h", m_tx_byte, want.tx));
                    end
                    if (m_run_last !== want.last) begin
                        flag_mismatch($sformatf("run_last got %b want %b",
                                                m_run_last, want.last));
                    end
                    if (m_packet_done !== want.done) begin
                        flag_mismatch($sformatf("packet_done got %b want %b",
                                                m_packet_done, want.done));
                    end
                end
            end
            // new mask whenever the phase wraps; at most three stalls in a row
            if (stall_phase == 4'd0) begin
                stall_mask = ($urandom_range(0, 1) == 0) ? 16'h0000
                                                         : 16'($urandom & $urandom & 16'h7777);
            end
            m_ready <= !stall_mask[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        // directed: SOH packet with field extremes, filler and kind flips
        plan_item(1'b0, 8'hFF, 1'b1, 1'b0);
        plan_item(1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(1'b1, 8'hA5, 1'b0, 1'b0);
        plan_item(1'b0, 8'h55, 1'b1, 1'b0);
        plan_item(1'b0, 8'hAA, 1'b0, 1'b0);
        plan_item(1'b1, 8'hFF, 1'b1, 1'b0);
        plan_item(1'b0, 8'h80, 1'b0, 1'b0);
        plan_item(1'b0, 8'h01, 1'b1, 1'b0);
        plan_rest(1'b0, 1'b0);

        // second SOH packet with noisy fields, back to back
        plan_packet(1'b1, 1'b1, 1'b1);

        // directed: STX packet opened after SOH, filler 0x1A, kind flip
        plan_item(1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(1'b1, 8'h3C, 1'b1, 1'b0);
        plan_item(1'b0, 8'hFF, 1'b1, 1'b0);

        // leave the STX packet open at the end
        repeat ($urandom_range(50, 70)) begin
            plan_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_pending.size() != 0 || s_valid) @(posedge aclk);
        while (bytes_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && bytes_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #500_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
